/* rtl/core/hta_pkg.sv */
package hta_pkg;

    // Fixed field widths of the request and response transfers.
    localparam int HANDLE_W = 9;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_TAKE = 2'd0,
        CMD_GIVE = 2'd1,
        CMD_SET  = 2'd2,
        CMD_GET  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the request and launch the table reads
        logic exec;     // apply the update and load the response register
    } t_ctrl;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // response register can take a new result this cycle
    } t_stat;

endpackage

/* rtl/core/hta_req_if.sv */
interface hta_req_if;
    logic                          valid;
    logic                          ready;
    hta_pkg::t_cmd                 cmd;
    logic [hta_pkg::HANDLE_W-1:0]  handle_in;
    logic [hta_pkg::DATA_W-1:0]    value_in;

    modport source (output valid, output cmd, output handle_in, output value_in, input ready);
    modport sink   (input valid, input cmd, input handle_in, input value_in, output ready);
endinterface

/* rtl/core/hta_rsp_if.sv */
interface hta_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hta_pkg::HANDLE_W-1:0]  handle_out;
    logic [hta_pkg::DATA_W-1:0]    value_out;
    logic                          ok;

    modport source (output valid, output handle_out, output value_out, output ok, input ready);
    modport sink   (input valid, input handle_out, input value_out, input ok, output ready);
endinterface

/* rtl/core/hta_ctrl.sv */
module hta_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  hta_pkg::t_stat i_stat,
    output hta_pkg::t_ctrl o_ctrl
);

    hta_pkg::t_state r_state;
    hta_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hta_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.exec    = 1'b0;
        unique case (r_state)
            hta_pkg::ST_IDLE: begin
                // No request is taken while reset is held.
                o_req_ready = i_rst_n;
                if (i_rst_n && i_req_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = hta_pkg::ST_EXEC;
                end
            end
            hta_pkg::ST_EXEC: begin
                // Hold the operation until the response register has room.
                if (i_stat.out_free) begin
                    o_ctrl.exec = 1'b1;
                    n_state     = hta_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hta_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/hta_dp.sv */
module hta_dp #(
    parameter int SLOTS_PER_UNIT = 64,
    parameter int UNIT_COUNT     = 8,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hta_pkg::t_ctrl               i_ctrl,
    output hta_pkg::t_stat               o_stat,
    input  hta_pkg::t_cmd                i_cmd,
    input  logic [hta_pkg::HANDLE_W-1:0] i_handle_in,
    input  logic [hta_pkg::DATA_W-1:0]   i_value_in,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic [hta_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [hta_pkg::DATA_W-1:0]   o_value_out,
    output logic                         o_ok
);

    localparam int TOTAL = UNIT_COUNT * SLOTS_PER_UNIT;
    localparam int HW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int UW    = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int SW    = (SLOTS_PER_UNIT > 1) ? $clog2(SLOTS_PER_UNIT) : 1;
    localparam int CW    = $clog2(SLOTS_PER_UNIT + 1);
    // Reciprocal for handle / SLOTS_PER_UNIT, exact over every 9-bit handle.
    localparam int RSH   = hta_pkg::HANDLE_W + $clog2(SLOTS_PER_UNIT);
    localparam int RECIP = ((2 ** RSH) + SLOTS_PER_UNIT - 1) / SLOTS_PER_UNIT;
    localparam int PW    = hta_pkg::HANDLE_W + RSH + 1;

    // Allocation bitmap, one row per unit; row valid bits stand in for reset.
    logic [SLOTS_PER_UNIT-1:0] mem_alloc [UNIT_COUNT];
    logic [UNIT_COUNT-1:0]     r_row_valid;
    logic [VALUE_WIDTH-1:0]    mem_val [TOTAL];
    logic [CW-1:0]             r_free [UNIT_COUNT];

    hta_pkg::t_cmd             r_cmd;
    logic [HW-1:0]             r_hidx;
    logic [VALUE_WIDTH-1:0]    r_value;
    logic [UW-1:0]             r_unit;
    logic                      r_full;
    logic                      r_in_range;
    logic [SLOTS_PER_UNIT-1:0] r_row_q;
    logic                      r_row_ok;
    logic [VALUE_WIDTH-1:0]    r_rd_value;

    logic                      r_out_valid;
    logic [hta_pkg::HANDLE_W-1:0] r_handle_out;
    logic [hta_pkg::DATA_W-1:0]   r_value_out;
    logic                      r_ok;

    logic [UW-1:0]             pick_unit;
    logic                      pick_none;
    logic [PW-1:0]             quot_prod;
    logic [UW-1:0]             h_unit;
    logic [UW-1:0]             n_unit;
    logic                      n_in_range;

    logic [SLOTS_PER_UNIT-1:0] row;
    logic [SLOTS_PER_UNIT-1:0] row_new;
    logic [HW:0]               base;
    logic [SW-1:0]             slot_h;
    logic [SW-1:0]             slot_t;
    logic [HW:0]               take_idx;
    logic                      live;
    logic                      do_take;
    logic                      do_give;
    logic                      do_set;
    logic                      do_get;

    // ---- request side: unit selection for the row read ----
    always_comb begin
        pick_unit = '0;
        pick_none = 1'b1;
        for (int u = UNIT_COUNT - 1; u >= 0; u--) begin
            if (r_free[u] != '0) begin
                pick_unit = UW'(u);
                pick_none = 1'b0;
            end
        end
    end

    assign quot_prod  = PW'(i_handle_in) * PW'(RECIP);
    assign h_unit     = UW'(quot_prod >> RSH);
    assign n_in_range = (int'(i_handle_in) < TOTAL);
    assign n_unit     = (i_cmd == hta_pkg::CMD_TAKE) ? pick_unit : h_unit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd      <= i_cmd;
            r_hidx     <= HW'(i_handle_in);
            r_value    <= VALUE_WIDTH'(i_value_in);
            r_unit     <= n_unit;
            r_full     <= pick_none;
            r_in_range <= n_in_range;
            r_row_q    <= mem_alloc[n_unit];
            r_row_ok   <= r_row_valid[n_unit];
            r_rd_value <= mem_val[HW'(i_handle_in)];
        end
    end

    // ---- execute side ----
    assign row      = r_row_ok ? r_row_q : '0;
    assign base     = (HW+1)'(r_unit) * (HW+1)'(SLOTS_PER_UNIT);
    assign slot_h   = SW'((HW+1)'(r_hidx) - base);
    assign take_idx = base + (HW+1)'(slot_t);
    assign live     = r_in_range && row[slot_h];

    always_comb begin
        slot_t = '0;
        for (int k = SLOTS_PER_UNIT - 1; k >= 0; k--) begin
            if (!row[k]) begin
                slot_t = SW'(k);
            end
        end
    end

    always_comb begin
        do_take = 1'b0;
        do_give = 1'b0;
        do_set  = 1'b0;
        do_get  = 1'b0;
        unique case (r_cmd)
            hta_pkg::CMD_TAKE: do_take = !r_full;
            hta_pkg::CMD_GIVE: do_give = live;
            hta_pkg::CMD_SET:  do_set  = live;
            hta_pkg::CMD_GET:  do_get  = live;
            default: ;
        endcase
    end

    always_comb begin
        row_new = row;
        if (do_take) begin
            row_new[slot_t] = 1'b1;
        end else begin
            row_new[slot_h] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && (do_take || do_give)) begin
            mem_alloc[r_unit] <= row_new;
        end
        if (i_ctrl.exec && do_take) begin
            mem_val[HW'(take_idx)] <= '1;
        end else if (i_ctrl.exec && do_set) begin
            mem_val[r_hidx] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            for (int u = 0; u < UNIT_COUNT; u++) begin
                r_free[u] <= CW'(SLOTS_PER_UNIT);
            end
        end else if (i_ctrl.exec) begin
            if (do_take || do_give) begin
                r_row_valid[r_unit] <= 1'b1;
            end
            if (do_take) begin
                r_free[r_unit] <= r_free[r_unit] - CW'(1);
            end else if (do_give) begin
                r_free[r_unit] <= r_free[r_unit] + CW'(1);
            end
        end
    end

    // ---- response register ----
    assign o_stat.out_free = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_handle_out <= do_take ? hta_pkg::HANDLE_W'(take_idx) : '0;
            r_value_out  <= do_get ? hta_pkg::DATA_W'(r_rd_value) : '0;
            r_ok         <= do_take || do_give || do_set || do_get;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_handle_out = r_handle_out;
    assign o_value_out  = r_value_out;
    assign o_ok         = r_ok;

endmodule

/* rtl/core/handle_table_allocator.sv */
// Handle table allocator: a two-level table of UNIT_COUNT units with
// SLOTS_PER_UNIT slots each, handing out the lowest free handle on take.
// Requests arrive on i_req (cmd, handle_in, value_in) and each one yields
// exactly one response transfer on o_rsp (handle_out, value_out, ok).
// In the accepting cycle of a request the unit is chosen and its allocation
// row and the addressed value are read into registers; in the execute state
// that follows, once the response register has room, the row is searched,
// the tables are updated and the response register is loaded; the response
// is driven from that register. A new request is accepted only after the
// current one has executed.
// The response register decouples the two sides: a new request is accepted
// while an earlier response still waits. If the receiver stalls with a
// response pending, the following request holds in its execute cycle until
// the response register frees up, and no further request is accepted.
// Reset empties the table (every handle free, every unit count full);
// stored values are left undefined since take always writes them.
module handle_table_allocator #(
    parameter int SLOTS_PER_UNIT = 64,
    parameter int UNIT_COUNT     = 8,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hta_req_if.sink   i_req,
    hta_rsp_if.source o_rsp
);

    hta_pkg::t_ctrl ctrl;
    hta_pkg::t_stat stat;

    // The controller only sequences; all table state lives in the datapath.
    hta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    hta_dp #(
        .SLOTS_PER_UNIT (SLOTS_PER_UNIT),
        .UNIT_COUNT     (UNIT_COUNT),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_cmd        (i_req.cmd),
        .i_handle_in  (i_req.handle_in),
        .i_value_in   (i_req.value_in),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_handle_out (o_rsp.handle_out),
        .o_value_out  (o_rsp.value_out),
        .o_ok         (o_rsp.ok)
    );

endmodule
